// File: rtl/pmc_pkg.sv
// Package for the prefix match counter: field widths, function codes and
// the command/status structs between controller and datapath.
// No dependencies.
package pmc_pkg;

   localparam int PATTERN_MAX_DEFAULT = 64;
   localparam int TEXT_MAX_DEFAULT    = 4096;

   localparam int FUNC_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int PREFIX_W = 7;
   localparam int COUNT_W  = 13;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PAT    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TEXT   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd3;

   typedef struct packed {
      logic clear_all;
      logic pat_append;
      logic txt_append;
      logic clr_start;
      logic clr_step;
      logic build_start;
      logic scan_start;
      logic zarr_read;
      logic z_zero;
      logic z_from_box;
      logic cmp_issue;
      logic z_inc;
      logic zarr_write;
      logic hist_read;
      logic hist_incr;
      logic advance;
      logic out_start;
      logic out_read;
      logic out_emit;
      logic empty_emit;
   } cmd_type;

   typedef struct packed {
      logic lt_lim;
      logic in_box;
      logic can_ext;
      logic chars_eq;
      logic z_nz;
      logic m_zero;
      logic k_last;
      logic out_free;
      logic phase_scan;
   } status_type;

endpackage

// File: rtl/pmc_req_if.sv
// Request channel of the prefix match counter: valid/ready plus payload.
// Depends on pmc_pkg.
interface pmc_req_if;
   logic                        valid;
   logic                        ready;
   logic [pmc_pkg::FUNC_W-1:0]  func;
   logic [pmc_pkg::CHAR_W-1:0]  char_in;

   modport source (output valid, output func, output char_in, input ready);
   modport sink   (input valid, input func, input char_in, output ready);
endinterface

// File: rtl/pmc_rsp_if.sv
// Response channel of the prefix match counter: valid/ready plus payload.
// Depends on pmc_pkg.
interface pmc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pmc_pkg::PREFIX_W-1:0]  prefix_len;
   logic [pmc_pkg::COUNT_W-1:0]   match_count;
   logic                          last;
   logic                          overflow;

   modport source (output valid, output prefix_len, output match_count,
                   output last, output overflow, input ready);
   modport sink   (input valid, input prefix_len, input match_count,
                   input last, input overflow, output ready);
endinterface

// File: rtl/pmc_ctrl.sv
// Controller of the prefix match counter: sequences load, Z-array build,
// text scan and report. Depends on pmc_pkg.
module pmc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [pmc_pkg::FUNC_W-1:0]  req_func,
   output logic                        req_ready,
   input  pmc_pkg::status_type         status,
   output pmc_pkg::cmd_type            cmd
);
   import pmc_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLR   = 4'd1;
   localparam logic [3:0] S_POS   = 4'd2;
   localparam logic [3:0] S_ZRD   = 4'd3;
   localparam logic [3:0] S_CMP   = 4'd4;
   localparam logic [3:0] S_CMPW  = 4'd5;
   localparam logic [3:0] S_FIN   = 4'd6;
   localparam logic [3:0] S_HINC  = 4'd7;
   localparam logic [3:0] S_ORD   = 4'd8;
   localparam logic [3:0] S_OEMIT = 4'd9;
   localparam logic [3:0] S_EMPTY = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_func)
                  FUNC_CLEAR: cmd.clear_all  = 1'b1;
                  FUNC_PAT:   cmd.pat_append = 1'b1;
                  FUNC_TEXT:  cmd.txt_append = 1'b1;
                  FUNC_REPORT: begin
                     if (status.m_zero) begin
                        state_in = S_EMPTY;
                     end else begin
                        cmd.clr_start = 1'b1;
                        state_in      = S_CLR;
                     end
                  end
               endcase
            end
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (status.k_last) begin
               cmd.build_start = 1'b1;
               state_in        = S_POS;
            end
         end
         S_POS: begin
            priority if (!status.lt_lim) begin
               if (status.phase_scan) begin
                  cmd.out_start = 1'b1;
                  state_in      = S_ORD;
               end else begin
                  cmd.scan_start = 1'b1;
               end
            end else if (status.in_box) begin
               cmd.zarr_read = 1'b1;
               state_in      = S_ZRD;
            end else begin
               cmd.z_zero = 1'b1;
               state_in   = S_CMP;
            end
         end
         S_ZRD: begin
            cmd.z_from_box = 1'b1;
            state_in       = S_CMP;
         end
         S_CMP: begin
            if (status.can_ext) begin
               cmd.cmp_issue = 1'b1;
               state_in      = S_CMPW;
            end else begin
               state_in = S_FIN;
            end
         end
         S_CMPW: begin
            if (status.chars_eq) begin
               cmd.z_inc = 1'b1;
               state_in  = S_CMP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (status.phase_scan && status.z_nz) begin
               cmd.hist_read = 1'b1;
               state_in      = S_HINC;
            end else begin
               cmd.zarr_write = !status.phase_scan;
               cmd.advance    = 1'b1;
               state_in       = S_POS;
            end
         end
         S_HINC: begin
            cmd.hist_incr = 1'b1;
            cmd.advance   = 1'b1;
            state_in      = S_POS;
         end
         S_ORD: begin
            cmd.out_read = 1'b1;
            state_in     = S_OEMIT;
         end
         S_OEMIT: begin
            if (status.out_free) begin
               cmd.out_emit = 1'b1;
               state_in     = status.k_last ? S_IDLE : S_ORD;
            end
         end
         S_EMPTY: begin
            if (status.out_free) begin
               cmd.empty_emit = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/pmc_datapath.sv
// Datapath of the prefix match counter: pattern, text, Z-array and
// histogram memories, Z-box window, counters and the response register.
// Depends on pmc_pkg.
module pmc_datapath #(
   parameter int PATTERN_MAX = pmc_pkg::PATTERN_MAX_DEFAULT,
   parameter int TEXT_MAX    = pmc_pkg::TEXT_MAX_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pmc_pkg::CHAR_W-1:0]    req_char,
   input  pmc_pkg::cmd_type              cmd,
   output pmc_pkg::status_type           status,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [pmc_pkg::PREFIX_W-1:0]  rsp_prefix_len,
   output logic [pmc_pkg::COUNT_W-1:0]   rsp_match_count,
   output logic                          rsp_last,
   output logic                          rsp_overflow
);
   import pmc_pkg::*;

   localparam int PW  = $clog2(PATTERN_MAX + 1);
   localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int TW  = $clog2(TEXT_MAX + 1);
   localparam int TAW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
   localparam int IW  = (TW > PW) ? TW : PW;
   localparam int SW  = IW + 1;

   logic [CHAR_W-1:0]  pat_mem  [PATTERN_MAX];
   logic [CHAR_W-1:0]  txt_mem  [TEXT_MAX];
   logic [PW-1:0]      zarr_mem [PATTERN_MAX];
   logic [COUNT_W-1:0] hist_mem [PATTERN_MAX];

   logic [PW-1:0]       plen_ff, plen_in;
   logic [TW-1:0]       tlen_ff, tlen_in;
   logic                ovf_ff, ovf_in;
   logic                phase_ff, phase_in;
   logic [IW-1:0]       i_ff, i_in;
   logic [IW-1:0]       l_ff, l_in;
   logic [IW-1:0]       r_ff, r_in;
   logic [PW-1:0]       z_ff, z_in;
   logic [PAW-1:0]      k_ff, k_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PREFIX_W-1:0] rsp_len_ff, rsp_len_in;
   logic [COUNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic [PW-1:0]       zq_ff;
   logic [CHAR_W-1:0]   pa_ff, pb_ff, tq_ff;
   logic [COUNT_W-1:0]  hq_ff;

   logic [IW-1:0]  lim;
   logic [SW-1:0]  iz;
   logic [IW-1:0]  box_len;
   logic [PW-1:0]  z_box;
   logic [IW-1:0]  zoff;
   logic [PW-1:0]  zm1;
   logic [PW-1:0]  kp1;
   logic           pfull, tfull, out_free;

   assign lim      = phase_ff ? IW'(tlen_ff) : IW'(plen_ff);
   assign iz       = SW'(i_ff) + SW'(z_ff);
   assign box_len  = r_ff - i_ff;
   assign z_box    = (box_len < IW'(zq_ff)) ? PW'(box_len) : zq_ff;
   assign zoff     = i_ff - l_ff;
   assign zm1      = z_ff - PW'(1);
   assign kp1      = PW'(k_ff) + PW'(1);
   assign pfull    = (plen_ff == PW'(PATTERN_MAX));
   assign tfull    = (tlen_ff == TW'(TEXT_MAX));
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status.lt_lim     = (i_ff < lim);
      status.in_box     = (i_ff < r_ff);
      status.can_ext    = (z_ff < plen_ff) && (iz < SW'(lim));
      status.chars_eq   = ((phase_ff ? tq_ff : pb_ff) == pa_ff);
      status.z_nz       = (z_ff != '0);
      status.m_zero     = (plen_ff == '0);
      status.k_last     = (kp1 == plen_ff);
      status.out_free   = out_free;
      status.phase_scan = phase_ff;
   end

   always_comb begin
      plen_in      = plen_ff;
      tlen_in      = tlen_ff;
      ovf_in       = ovf_ff;
      phase_in     = phase_ff;
      i_in         = i_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      z_in         = z_ff;
      k_in         = k_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_len_in   = rsp_len_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (cmd.clear_all) begin
         plen_in = '0;
         tlen_in = '0;
         ovf_in  = 1'b0;
      end
      if (cmd.pat_append) begin
         if (pfull) ovf_in = 1'b1;
         else       plen_in = plen_ff + PW'(1);
      end
      if (cmd.txt_append) begin
         if (tfull) ovf_in = 1'b1;
         else       tlen_in = tlen_ff + TW'(1);
      end
      if (cmd.clr_start || cmd.out_start) k_in = '0;
      if (cmd.clr_step || cmd.out_emit)   k_in = k_ff + PAW'(1);
      if (cmd.build_start) begin
         phase_in = 1'b0;
         i_in     = IW'(1);
         l_in     = '0;
         r_in     = '0;
      end
      if (cmd.scan_start) begin
         phase_in = 1'b1;
         i_in     = '0;
         l_in     = '0;
         r_in     = '0;
         total_in = '0;
      end
      if (cmd.z_zero)     z_in = '0;
      if (cmd.z_from_box) z_in = z_box;
      if (cmd.z_inc)      z_in = z_ff + PW'(1);
      if (cmd.hist_incr)  total_in = total_ff + COUNT_W'(1);
      if (cmd.advance) begin
         i_in = i_ff + IW'(1);
         if (iz > SW'(r_ff)) begin
            r_in = iz[IW-1:0];
            l_in = i_ff;
         end
      end
      if (cmd.out_emit) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = PREFIX_W'(kp1);
         rsp_cnt_in   = total_ff;
         rsp_last_in  = (kp1 == plen_ff);
         rsp_ovf_in   = ovf_ff;
         total_in     = total_ff - hq_ff;
      end
      if (cmd.empty_emit) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = '0;
         rsp_cnt_in   = '0;
         rsp_last_in  = 1'b1;
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         tlen_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         tlen_ff      <= tlen_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      i_ff        <= i_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      z_ff        <= z_in;
      k_ff        <= k_in;
      total_ff    <= total_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // pattern: one write port, two read ports
   always_ff @(posedge clock) begin
      if (cmd.pat_append && !pfull) pat_mem[plen_ff[PAW-1:0]] <= req_char;
      if (cmd.cmp_issue) begin
         pa_ff <= pat_mem[z_ff[PAW-1:0]];
         pb_ff <= pat_mem[iz[PAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.txt_append && !tfull) txt_mem[tlen_ff[TAW-1:0]] <= req_char;
      if (cmd.cmp_issue) tq_ff <= txt_mem[iz[TAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.zarr_write) zarr_mem[i_ff[PAW-1:0]] <= z_ff;
      if (cmd.zarr_read)  zq_ff <= zarr_mem[zoff[PAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step)  hist_mem[k_ff] <= '0;
      if (cmd.hist_incr) hist_mem[zm1[PAW-1:0]] <= hq_ff + COUNT_W'(1);
      if (cmd.hist_read) hq_ff <= hist_mem[zm1[PAW-1:0]];
      if (cmd.out_read)  hq_ff <= hist_mem[k_ff];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prefix_len  = rsp_len_ff;
   assign rsp_match_count = rsp_cnt_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

// File: rtl/prefix_match_counter.sv
// Prefix match counter. Clear and append: one transfer per cycle while no
// report is running, no result. Report with pattern length m, text length n:
// histogram clear, then Z-array build and text scan (byte compares bounded by
// the Z-box to about 2(m+n)), then one result per prefix length, each held
// until accepted. Empty pattern: a single result with prefix length zero.
// Synchronous reset clears lengths, overflow flag and control; stores undefined.
module prefix_match_counter #(
   parameter int PATTERN_MAX = pmc_pkg::PATTERN_MAX_DEFAULT,
   parameter int TEXT_MAX    = pmc_pkg::TEXT_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   pmc_req_if.sink     req_chan,
   pmc_rsp_if.source   rsp_chan
);
   import pmc_pkg::*;

   cmd_type    cmd;
   status_type status;

   pmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pmc_datapath #(
      .PATTERN_MAX (PATTERN_MAX),
      .TEXT_MAX    (TEXT_MAX)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_char        (req_chan.char_in),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_prefix_len  (rsp_chan.prefix_len),
      .rsp_match_count (rsp_chan.match_count),
      .rsp_last        (rsp_chan.last),
      .rsp_overflow    (rsp_chan.overflow)
   );

endmodule

// File: rtl/pmc_checker.sv
// Port-level checks for the prefix match counter, bound to the top level.
// Depends on pmc_pkg.
module pmc_sva (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pmc_pkg::PREFIX_W-1:0]  rsp_prefix_len,
   input logic [pmc_pkg::COUNT_W-1:0]   rsp_match_count,
   input logic                          rsp_last
);
   import pmc_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prefix_len)
         && $stable(rsp_match_count) && $stable(rsp_last))
      else $error("stalled response changed");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_prefix_len == '0 |-> rsp_last && rsp_match_count == '0)
      else $error("empty-pattern result malformed");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_prefix_len != '0)
      else $error("non-final result with zero prefix length");

endmodule

bind prefix_match_counter pmc_sva u_pmc_sva (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_prefix_len  (rsp_chan.prefix_len),
   .rsp_match_count (rsp_chan.match_count),
   .rsp_last        (rsp_chan.last)
);
